### design/bpu_pkg.sv
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared types and constants for the depth pixel back-projection unit.
// ----------------------------------------------------------------------------
package bpu_pkg;

  // default parameter values
  localparam int COORD_BITS_DEF    = 12;
  localparam int FRACTION_BITS_DEF = 16;

  // fixed field widths
  localparam int DEPTH_W   = 16;
  localparam int PIX_W     = 12;
  localparam int COLOR_W   = 8;
  localparam int PRINC_W   = 16;
  localparam int RECIP_W   = 24;
  localparam int POINT_W   = 24;
  localparam int RECIP_HALF = 12;     // recip split into two 12-bit halves
  localparam int RECIP_FRAC = 24;     // Q0.24 reciprocals
  localparam int PRINC_FRAC = 4;      // Q12.4 principal point
  localparam int Q_SHIFT_HI = 16;     // 28 total after the half split

  // saturation limits of the signed coordinates
  localparam int unsigned POS_MAX     = 8388607;
  localparam int unsigned NEG_MAG_MAX = 8388608;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_FOCAL_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_FOCAL_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_DEPTH_SCALE = 3'd4;

  localparam logic [PRINC_W-1:0] PRINCIPAL_X_RST       = 16'd5120;
  localparam logic [PRINC_W-1:0] PRINCIPAL_Y_RST       = 16'd3840;
  localparam logic [RECIP_W-1:0] RECIP_FOCAL_X_RST     = 24'd32388;
  localparam logic [RECIP_W-1:0] RECIP_FOCAL_Y_RST     = 24'd32388;
  localparam logic [RECIP_W-1:0] RECIP_DEPTH_SCALE_RST = 24'd16777;

  // camera intrinsics as held in the register file
  typedef struct packed {
    logic [PRINC_W-1:0] principal_x;
    logic [PRINC_W-1:0] principal_y;
    logic [RECIP_W-1:0] recip_focal_x;
    logic [RECIP_W-1:0] recip_focal_y;
    logic [RECIP_W-1:0] recip_depth_scale;
  } bpu_cfg_t;

  // per-stage load enables of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } bpu_ld_t;

  // side data carried alongside the arithmetic
  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic               point_valid;
    logic               last_of_frame;
  } bpu_meta_t;

endpackage

### design/bpu_pixel_if.sv
// ----------------------------------------------------------------------------
// bpu_pixel_if
// Input pixel channel: valid/ready plus one RGB-D pixel word.
// ----------------------------------------------------------------------------
interface bpu_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [bpu_pkg::DEPTH_W-1:0] raw_depth;
  logic [bpu_pkg::PIX_W-1:0]   pixel_row;
  logic [bpu_pkg::PIX_W-1:0]   pixel_col;
  logic [bpu_pkg::COLOR_W-1:0] in_blue;
  logic [bpu_pkg::COLOR_W-1:0] in_green;
  logic [bpu_pkg::COLOR_W-1:0] in_red;
  logic                        frame_end;

  modport source (
    output valid, raw_depth, pixel_row, pixel_col, in_blue, in_green, in_red, frame_end,
    input  ready
  );
  modport sink (
    input  valid, raw_depth, pixel_row, pixel_col, in_blue, in_green, in_red, frame_end,
    output ready
  );
endinterface

### design/bpu_point_if.sv
// ----------------------------------------------------------------------------
// bpu_point_if
// Output point channel: valid/ready plus one 3-D point word.
// ----------------------------------------------------------------------------
interface bpu_point_if;
  logic                               valid;
  logic                               ready;
  logic signed [bpu_pkg::POINT_W-1:0] point_x;
  logic signed [bpu_pkg::POINT_W-1:0] point_y;
  logic [bpu_pkg::POINT_W-1:0]        point_z;
  logic [bpu_pkg::COLOR_W-1:0]        out_blue;
  logic [bpu_pkg::COLOR_W-1:0]        out_green;
  logic [bpu_pkg::COLOR_W-1:0]        out_red;
  logic                               point_valid;
  logic                               last_of_frame;

  modport source (
    output valid, point_x, point_y, point_z, out_blue, out_green, out_red,
           point_valid, last_of_frame,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, out_blue, out_green, out_red,
           point_valid, last_of_frame,
    output ready
  );
endinterface

### design/bpu_cfg_if.sv
// ----------------------------------------------------------------------------
// bpu_cfg_if
// Configuration write channel: valid/ready, register index and data word.
// ----------------------------------------------------------------------------
interface bpu_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bpu_pkg::CFG_IDX_W-1:0]  index;
  logic [bpu_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/bpu_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpu_cfg_regs
// Register file for the camera intrinsics; always ready for a write word.
// ----------------------------------------------------------------------------
module bpu_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  bpu_cfg_if.sink           cfg_write,
  output bpu_pkg::bpu_cfg_t cfg
);

  bpu_pkg::bpu_cfg_t cfg_r;
  bpu_pkg::bpu_cfg_t cfg_nxt;

  assign cfg_write.ready = 1'b1;
  assign cfg = cfg_r;

  // decode one write word; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write.valid) begin
      case (cfg_write.index)
        bpu_pkg::REG_PRINCIPAL_X:
          cfg_nxt.principal_x = cfg_write.data[bpu_pkg::PRINC_W-1:0];
        bpu_pkg::REG_PRINCIPAL_Y:
          cfg_nxt.principal_y = cfg_write.data[bpu_pkg::PRINC_W-1:0];
        bpu_pkg::REG_RECIP_FOCAL_X:
          cfg_nxt.recip_focal_x = cfg_write.data[bpu_pkg::RECIP_W-1:0];
        bpu_pkg::REG_RECIP_FOCAL_Y:
          cfg_nxt.recip_focal_y = cfg_write.data[bpu_pkg::RECIP_W-1:0];
        bpu_pkg::REG_RECIP_DEPTH_SCALE:
          cfg_nxt.recip_depth_scale = cfg_write.data[bpu_pkg::RECIP_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.principal_x       <= bpu_pkg::PRINCIPAL_X_RST;
      cfg_r.principal_y       <= bpu_pkg::PRINCIPAL_Y_RST;
      cfg_r.recip_focal_x     <= bpu_pkg::RECIP_FOCAL_X_RST;
      cfg_r.recip_focal_y     <= bpu_pkg::RECIP_FOCAL_Y_RST;
      cfg_r.recip_depth_scale <= bpu_pkg::RECIP_DEPTH_SCALE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### design/bpu_depth_path.sv
// ----------------------------------------------------------------------------
// bpu_depth_path
// Depth to z: one 16x24 multiply, shift to the output fraction, saturate.
// ----------------------------------------------------------------------------
module bpu_depth_path #(
  parameter int FRACTION_BITS = bpu_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  bpu_pkg::bpu_ld_t            ld,
  input  logic [bpu_pkg::DEPTH_W-1:0] raw_depth,
  input  logic [bpu_pkg::RECIP_W-1:0] recip_depth_scale,
  output logic [bpu_pkg::POINT_W-1:0] z_s1,
  output logic [bpu_pkg::POINT_W-1:0] z_out
);

  localparam int PROD_W = bpu_pkg::DEPTH_W + bpu_pkg::RECIP_W;
  localparam int ZSHIFT = bpu_pkg::RECIP_FRAC - FRACTION_BITS;

  logic [PROD_W-1:0]           prod1_r;
  logic [PROD_W-1:0]           prod1_nxt;
  logic [PROD_W-1:0]           shifted;
  logic [bpu_pkg::POINT_W-1:0] z2_r;
  logic [bpu_pkg::POINT_W-1:0] z3_r;
  logic [bpu_pkg::POINT_W-1:0] z4_r;

  // stage 1: raw product
  assign prod1_nxt = PROD_W'(raw_depth) * PROD_W'(recip_depth_scale);

  // stage 1 output: drop fraction bits and clamp to 24 bits
  assign shifted = prod1_r >> ZSHIFT;
  assign z_s1 = (|shifted[PROD_W-1:bpu_pkg::POINT_W]) ? {bpu_pkg::POINT_W{1'b1}}
                                                       : shifted[bpu_pkg::POINT_W-1:0];
  assign z_out = z4_r;

  always_ff @(posedge clk) begin
    if (ld.s1) prod1_r <= prod1_nxt;
    if (ld.s2) z2_r    <= z_s1;
    if (ld.s3) z3_r    <= z2_r;
    if (ld.s4) z4_r    <= z3_r;
  end

endmodule

### design/bpu_axis_path.sv
// ----------------------------------------------------------------------------
// bpu_axis_path
// One lateral axis: offset from principal point, times z, times 1/f (split
// into two 12-bit halves), truncate toward zero and saturate to 24 bits.
// ----------------------------------------------------------------------------
module bpu_axis_path #(
  parameter int COORD_BITS = bpu_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  bpu_pkg::bpu_ld_t                   ld,
  input  logic [bpu_pkg::PIX_W-1:0]          coord,
  input  logic [bpu_pkg::PRINC_W-1:0]        principal,
  input  logic [bpu_pkg::RECIP_W-1:0]        recip,
  input  logic [bpu_pkg::POINT_W-1:0]        z_s1,
  output logic signed [bpu_pkg::POINT_W-1:0] coord_out
);

  localparam int C4_W   = COORD_BITS + bpu_pkg::PRINC_FRAC;
  localparam int OFF_W  = (C4_W > bpu_pkg::PRINC_W) ? C4_W : bpu_pkg::PRINC_W;
  localparam int MAG_W  = OFF_W + bpu_pkg::POINT_W;
  localparam int PP_W   = MAG_W + bpu_pkg::RECIP_HALF;
  localparam int SUM_W  = PP_W + 1;
  localparam int Q_W    = SUM_W - bpu_pkg::Q_SHIFT_HI;
  localparam int HALF   = bpu_pkg::RECIP_HALF;

  logic [COORD_BITS-1:0]       coord_c;
  logic [OFF_W-1:0]            c4;
  logic [OFF_W-1:0]            pe;
  logic                        neg1_nxt;
  logic [OFF_W-1:0]            off1_nxt;
  logic                        neg1_r;
  logic [OFF_W-1:0]            off1_r;
  logic                        neg2_r;
  logic [MAG_W-1:0]            mag2_r;
  logic                        neg3_r;
  logic [PP_W-1:0]             lo3_r;
  logic [PP_W-1:0]             hi3_r;
  logic [SUM_W-1:0]            sum;
  logic [Q_W-1:0]              q;
  logic [bpu_pkg::POINT_W-1:0] res4_nxt;
  logic [bpu_pkg::POINT_W-1:0] res4_r;

  // stage 1: signed offset as sign and magnitude, Q.4
  assign coord_c  = COORD_BITS'(coord);
  assign c4       = OFF_W'({coord_c, {bpu_pkg::PRINC_FRAC{1'b0}}});
  assign pe       = OFF_W'(principal);
  assign neg1_nxt = c4 < pe;
  assign off1_nxt = neg1_nxt ? (pe - c4) : (c4 - pe);

  // stage 4: recombine halves, drop 28 fraction bits, saturate, apply sign
  assign sum = SUM_W'(hi3_r) + SUM_W'(lo3_r >> HALF);
  assign q   = sum[SUM_W-1:bpu_pkg::Q_SHIFT_HI];

  always_comb begin
    if (neg3_r) begin
      if (q > Q_W'(bpu_pkg::NEG_MAG_MAX)) begin
        res4_nxt = bpu_pkg::POINT_W'(bpu_pkg::NEG_MAG_MAX);
      end else begin
        res4_nxt = bpu_pkg::POINT_W'(0) - q[bpu_pkg::POINT_W-1:0];
      end
    end else begin
      if (q > Q_W'(bpu_pkg::POS_MAX)) begin
        res4_nxt = bpu_pkg::POINT_W'(bpu_pkg::POS_MAX);
      end else begin
        res4_nxt = q[bpu_pkg::POINT_W-1:0];
      end
    end
  end

  assign coord_out = signed'(res4_r);

  // pipeline registers
  always_ff @(posedge clk) begin
    if (ld.s1) begin
      neg1_r <= neg1_nxt;
      off1_r <= off1_nxt;
    end
    if (ld.s2) begin
      neg2_r <= neg1_r;
      mag2_r <= MAG_W'(off1_r) * MAG_W'(z_s1);
    end
    if (ld.s3) begin
      neg3_r <= neg2_r;
      lo3_r  <= PP_W'(mag2_r) * PP_W'(recip[HALF-1:0]);
      hi3_r  <= PP_W'(mag2_r) * PP_W'(recip[bpu_pkg::RECIP_W-1:HALF]);
    end
    if (ld.s4) begin
      res4_r <= res4_nxt;
    end
  end

endmodule

### design/depth_pixel_backprojection_unit.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_unit
// Pinhole back-projection of RGB-D pixels to colored 3-D points.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock while the output is not stalled and
// returns its point from the output register. The four stages are:
// depth multiply and principal offset; z saturation and offset*z
// multiply; the 1/f multiply done as two 12-bit halves; recombination,
// saturation and the output register. Every stage holds its own valid
// bit and fills a bubble even while the output is stalled, so input is
// taken as long as any stage has room. Pixels with zero depth produce
// nothing unless they end a frame, in which case an all-zero word with
// point_valid low carries last_of_frame. Configuration writes are taken
// every cycle and must only be issued while the pipeline is empty.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_unit #(
  parameter int COORD_BITS    = bpu_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = bpu_pkg::FRACTION_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bpu_pixel_if.sink    in_pixel,
  bpu_point_if.source  out_point,
  bpu_cfg_if.sink      cfg_write
);

  bpu_pkg::bpu_cfg_t  cfg;
  bpu_pkg::bpu_ld_t   ld;
  bpu_pkg::bpu_meta_t meta0;
  bpu_pkg::bpu_meta_t meta1_r;
  bpu_pkg::bpu_meta_t meta2_r;
  bpu_pkg::bpu_meta_t meta3_r;
  bpu_pkg::bpu_meta_t meta4_r;

  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic rdy1, rdy2, rdy3, rdy4;
  logic keep;
  logic has_depth;

  logic [bpu_pkg::POINT_W-1:0]        z_s1;
  logic [bpu_pkg::POINT_W-1:0]        z_out;
  logic signed [bpu_pkg::POINT_W-1:0] x_out;
  logic signed [bpu_pkg::POINT_W-1:0] y_out;

  // register file
  bpu_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_write),
    .cfg       (cfg)
  );

  // per-stage flow control: a stage loads when empty or when it drains
  assign rdy4 = !v4_r || out_point.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_pixel.ready = rdy1;

  assign ld.s1 = rdy1;
  assign ld.s2 = rdy2;
  assign ld.s3 = rdy3;
  assign ld.s4 = rdy4;

  // zero-depth pixels are dropped unless they close a frame
  assign has_depth = in_pixel.raw_depth != '0;
  assign keep      = has_depth || in_pixel.frame_end;

  assign v1_nxt = rdy1 ? (in_pixel.valid && keep) : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = rdy3 ? v2_r : v3_r;
  assign v4_nxt = rdy4 ? v3_r : v4_r;

  // colors are cleared for an invalid frame-end word
  always_comb begin
    meta0.blue          = has_depth ? in_pixel.in_blue  : '0;
    meta0.green         = has_depth ? in_pixel.in_green : '0;
    meta0.red           = has_depth ? in_pixel.in_red   : '0;
    meta0.point_valid   = has_depth;
    meta0.last_of_frame = in_pixel.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // side data rides with the arithmetic
  always_ff @(posedge clk) begin
    if (ld.s1) meta1_r <= meta0;
    if (ld.s2) meta2_r <= meta1_r;
    if (ld.s3) meta3_r <= meta2_r;
    if (ld.s4) meta4_r <= meta3_r;
  end

  // z path
  bpu_depth_path #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_depth (
    .clk               (clk),
    .ld                (ld),
    .raw_depth         (in_pixel.raw_depth),
    .recip_depth_scale (cfg.recip_depth_scale),
    .z_s1              (z_s1),
    .z_out             (z_out)
  );

  // x uses the column, y the row
  bpu_axis_path #(
    .COORD_BITS (COORD_BITS)
  ) u_axis_x (
    .clk       (clk),
    .ld        (ld),
    .coord     (in_pixel.pixel_col),
    .principal (cfg.principal_x),
    .recip     (cfg.recip_focal_x),
    .z_s1      (z_s1),
    .coord_out (x_out)
  );

  bpu_axis_path #(
    .COORD_BITS (COORD_BITS)
  ) u_axis_y (
    .clk       (clk),
    .ld        (ld),
    .coord     (in_pixel.pixel_row),
    .principal (cfg.principal_y),
    .recip     (cfg.recip_focal_y),
    .z_s1      (z_s1),
    .coord_out (y_out)
  );

  // output word
  assign out_point.valid         = v4_r;
  assign out_point.point_x       = x_out;
  assign out_point.point_y       = y_out;
  assign out_point.point_z       = z_out;
  assign out_point.out_blue      = meta4_r.blue;
  assign out_point.out_green     = meta4_r.green;
  assign out_point.out_red       = meta4_r.red;
  assign out_point.point_valid   = meta4_r.point_valid;
  assign out_point.last_of_frame = meta4_r.last_of_frame;

  // an invalid point only ever closes a frame
  a_invalid_is_frame_end: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_point.valid && !out_point.point_valid) |-> out_point.last_of_frame
  ) else $error("invalid point word without frame end");

  // an invalid point carries all-zero coordinates and color
  a_invalid_is_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_point.valid && !out_point.point_valid) |->
      (out_point.point_x == 0 && out_point.point_y == 0 && out_point.point_z == 0 &&
       out_point.out_red == 0 && out_point.out_green == 0 && out_point.out_blue == 0)
  ) else $error("invalid point word has nonzero payload");

  // a stalled middle stage keeps its word
  a_stage_holds: assert property (
    @(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> v2_r
  ) else $error("stage 2 word lost under stall");

  // the pipeline takes input whenever the first stage is empty
  a_ready_when_empty: assert property (
    @(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_pixel.ready
  ) else $error("input refused with empty first stage");

endmodule
